// File: hw/rtl/apq_pkg.sv
package apq_pkg;

    // fixed field widths of the channels
    localparam int CMD_W    = 2;
    localparam int ELEM_W   = 32;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // result kinds chosen by the controller
    typedef logic [2:0] t_res_kind;
    localparam t_res_kind RES_PLAIN  = 3'd0;
    localparam t_res_kind RES_FULL   = 3'd1;
    localparam t_res_kind RES_EMPTY  = 3'd2;
    localparam t_res_kind RES_PEEK   = 3'd3;
    localparam t_res_kind RES_REMOVE = 3'd4;

    typedef struct packed {
        logic      latch;
        logic      ins_write;
        logic      scan_start;
        logic      scan_step;
        logic      shift_start;
        logic      shift_step;
        logic      count_dec;
        logic      res_load;
        t_res_kind res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic is_insert;
        logic is_peek;
        logic is_remove;
        logic full;
        logic empty;
        logic scan_last;
        logic best_last;
        logic shift_last;
    } t_dp_status;

endpackage

// File: hw/rtl/apq_cmd_if.sv
interface apq_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [apq_pkg::CMD_W-1:0]         command;
    logic signed [apq_pkg::ELEM_W-1:0] element;
    logic [apq_pkg::PRIO_W-1:0]        priority_req;

    modport source (output valid, output command, output element, output priority_req,
                    input ready);
    modport sink   (input valid, input command, input element, input priority_req,
                    output ready);
endinterface

// File: hw/rtl/apq_res_if.sv
interface apq_res_if;
    logic                              valid;
    logic                              ready;
    logic [apq_pkg::STATUS_W-1:0]      status;
    logic signed [apq_pkg::ELEM_W-1:0] out_element;
    logic [apq_pkg::PRIO_W-1:0]        out_priority;
    logic [apq_pkg::FILL_W-1:0]        fill_level;

    modport source (output valid, output status, output out_element, output out_priority,
                    output fill_level, input ready);
    modport sink   (input valid, input status, input out_element, input out_priority,
                    input fill_level, output ready);
endinterface

// File: hw/rtl/apq_dp.sv
module apq_dp #(
    parameter int CAPACITY      = 8,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  apq_pkg::t_dp_cmd                  i_cmd,
    output apq_pkg::t_dp_status               o_st,
    input  logic [apq_pkg::CMD_W-1:0]         i_command,
    input  logic signed [apq_pkg::ELEM_W-1:0] i_element,
    input  logic [apq_pkg::PRIO_W-1:0]        i_priority_req,
    output logic [apq_pkg::STATUS_W-1:0]      o_status,
    output logic signed [apq_pkg::ELEM_W-1:0] o_out_element,
    output logic [apq_pkg::PRIO_W-1:0]        o_out_priority,
    output logic [apq_pkg::FILL_W-1:0]        o_fill_level
);

    localparam int SW = (PRIORITY_BITS < apq_pkg::PRIO_W) ? PRIORITY_BITS : apq_pkg::PRIO_W;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = CW + 1;
    localparam int DW = apq_pkg::ELEM_W + SW;

    // entry store, element in the upper bits, priority in the lower
    logic [DW-1:0] mem [CAPACITY];

    logic [CW-1:0]                 r_count;
    logic [apq_pkg::CMD_W-1:0]     r_cmd;
    logic [apq_pkg::ELEM_W-1:0]    r_elem;
    logic [SW-1:0]                 r_prio;
    logic [DW-1:0]                 r_rd_data;
    logic [IW-1:0]                 r_scan;
    logic [IW-1:0]                 r_best_idx;
    logic [SW-1:0]                 r_best_prio;
    logic [apq_pkg::ELEM_W-1:0]    r_best_elem;
    logic [IW-1:0]                 r_wr_ptr;
    logic [apq_pkg::STATUS_W-1:0]  r_status;
    logic [apq_pkg::ELEM_W-1:0]    r_oelem;
    logic [apq_pkg::PRIO_W-1:0]    r_oprio;
    logic [apq_pkg::FILL_W-1:0]    r_fill;

    logic                       we;
    logic [IW-1:0]              wa;
    logic [DW-1:0]              wd;
    logic                       rd_en;
    logic [IW-1:0]              rd_addr;
    logic [AW-1:0]              scan_nxt;
    logic [AW-1:0]              best_nxt;
    logic [AW-1:0]              wr_nxt;
    logic [AW-1:0]              wr_nxt2;
    logic [AW-1:0]              count_x;
    logic [SW-1:0]              rd_prio;
    logic [apq_pkg::ELEM_W-1:0] rd_elem;
    logic                       take;

    assign scan_nxt = AW'(r_scan) + AW'(1);
    assign best_nxt = AW'(r_best_idx) + AW'(1);
    assign wr_nxt   = AW'(r_wr_ptr) + AW'(1);
    assign wr_nxt2  = AW'(r_wr_ptr) + AW'(2);
    assign count_x  = AW'(r_count);
    assign rd_prio  = r_rd_data[SW-1:0];
    assign rd_elem  = r_rd_data[DW-1 -: apq_pkg::ELEM_W];
    assign take     = (r_scan == '0) || (rd_prio > r_best_prio);

    always_comb begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        if (i_cmd.ins_write) begin
            we = 1'b1;
            wa = IW'(r_count);
            wd = {r_elem, r_prio};
        end else if (i_cmd.shift_step) begin
            we = 1'b1;
            wa = r_wr_ptr;
            wd = r_rd_data;
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (i_cmd.scan_start) begin
            rd_en = 1'b1;
        end else if (i_cmd.scan_step) begin
            rd_en   = scan_nxt < count_x;
            rd_addr = IW'(scan_nxt);
        end else if (i_cmd.shift_start) begin
            rd_en   = 1'b1;
            rd_addr = IW'(best_nxt);
        end else if (i_cmd.shift_step) begin
            rd_en   = wr_nxt2 < count_x;
            rd_addr = IW'(wr_nxt2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins_write) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.count_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd  <= i_command;
            r_elem <= i_element;
            r_prio <= i_priority_req[SW-1:0];
        end
        if (i_cmd.scan_start) begin
            r_scan <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan <= IW'(scan_nxt);
            if (take) begin
                r_best_idx  <= r_scan;
                r_best_prio <= rd_prio;
                r_best_elem <= rd_elem;
            end
        end
        if (i_cmd.shift_start) begin
            r_wr_ptr <= r_best_idx;
        end else if (i_cmd.shift_step) begin
            r_wr_ptr <= IW'(wr_nxt);
        end
        if (i_cmd.res_load) begin
            r_fill <= apq_pkg::FILL_W'(r_count);
            unique case (i_cmd.res_kind)
                apq_pkg::RES_FULL: begin
                    r_status <= apq_pkg::ST_FULL;
                    r_oelem  <= '0;
                    r_oprio  <= '0;
                end
                apq_pkg::RES_EMPTY: begin
                    r_status <= apq_pkg::ST_EMPTY;
                    r_oelem  <= '0;
                    r_oprio  <= '0;
                end
                apq_pkg::RES_PEEK: begin
                    r_status <= apq_pkg::ST_OK;
                    r_oelem  <= '0;
                    r_oprio  <= apq_pkg::PRIO_W'(r_best_prio);
                end
                apq_pkg::RES_REMOVE: begin
                    r_status <= apq_pkg::ST_OK;
                    r_oelem  <= r_best_elem;
                    r_oprio  <= apq_pkg::PRIO_W'(r_best_prio);
                end
                default: begin
                    r_status <= apq_pkg::ST_OK;
                    r_oelem  <= '0;
                    r_oprio  <= '0;
                end
            endcase
        end
    end

    assign o_st.is_insert  = r_cmd == apq_pkg::CMD_INSERT;
    assign o_st.is_peek    = r_cmd == apq_pkg::CMD_PEEK;
    assign o_st.is_remove  = r_cmd == apq_pkg::CMD_REMOVE;
    assign o_st.full       = r_count == CW'(CAPACITY);
    assign o_st.empty      = r_count == '0;
    assign o_st.scan_last  = scan_nxt == count_x;
    assign o_st.best_last  = best_nxt == count_x;
    assign o_st.shift_last = wr_nxt2 == count_x;

    assign o_status       = r_status;
    assign o_out_element  = r_oelem;
    assign o_out_priority = r_oprio;
    assign o_fill_level   = r_fill;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_write |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not add one entry");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.count_dec |=> r_count == $past(r_count) - CW'(1))
        else $error("remove did not drop one entry");

endmodule

// File: hw/rtl/apq_ctrl.sv
module apq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output apq_pkg::t_dp_cmd    o_cmd,
    input  apq_pkg::t_dp_status i_st
);

    localparam logic [2:0] S_IDLE        = 3'd0;
    localparam logic [2:0] S_DECODE      = 3'd1;
    localparam logic [2:0] S_SCAN        = 3'd2;
    localparam logic [2:0] S_SHIFT_START = 3'd3;
    localparam logic [2:0] S_SHIFT       = 3'd4;
    localparam logic [2:0] S_DONE        = 3'd5;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    apq_pkg::t_res_kind r_kind;
    apq_pkg::t_res_kind n_kind;
    logic               r_out_valid;
    logic               n_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_kind      = r_kind;
        n_out_valid = r_out_valid & ~i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_st.is_insert) begin
                    if (i_st.full) begin
                        n_kind = apq_pkg::RES_FULL;
                    end else begin
                        o_cmd.ins_write = 1'b1;
                        n_kind          = apq_pkg::RES_PLAIN;
                    end
                    n_state = S_DONE;
                end else if (i_st.is_peek || i_st.is_remove) begin
                    if (i_st.empty) begin
                        n_kind  = apq_pkg::RES_EMPTY;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end else begin
                    n_kind  = apq_pkg::RES_PLAIN;
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_st.scan_last) begin
                    if (i_st.is_peek) begin
                        n_kind  = apq_pkg::RES_PEEK;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SHIFT_START;
                    end
                end
            end
            S_SHIFT_START: begin
                n_kind = apq_pkg::RES_REMOVE;
                if (i_st.best_last) begin
                    o_cmd.count_dec = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.shift_start = 1'b1;
                    n_state           = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_st.shift_last) begin
                    o_cmd.count_dec = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.res_kind = r_kind;
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= apq_pkg::RES_PLAIN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    a_no_insert_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ins_write |-> !i_st.full)
        else $error("insert written into a full store");

    a_no_scan_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.scan_start || o_cmd.scan_step || o_cmd.shift_start) |-> !i_st.empty)
        else $error("scan or shift on an empty store");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");

endmodule

// File: hw/rtl/array_priority_queue_core.sv
// channel  | dir | handshake          | payload
// i_cmd    | in  | valid/ready        | command, element, priority_req
// o_res    | out | valid/ready        | status, out_element, out_priority, fill_level
//
// one command at a time; a beat is taken only while the controller is idle
// insert, full, empty and unused commands go from decode straight to the result
// state; peek first scans every stored entry for the top one, and remove also
// shifts any later entries down, one entry per cycle on the store port
// a finished result sits in the output register; the next beat is accepted
// while it waits, and the following result holds until it is taken
// synchronous active-low reset empties the queue; stored entries are not cleared
module array_priority_queue_core #(
    parameter int CAPACITY      = 8,
    parameter int PRIORITY_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    apq_cmd_if.sink   i_cmd,
    apq_res_if.source o_res
);

    // command and status between sequencer and datapath
    apq_pkg::t_dp_cmd    dp_cmd;
    apq_pkg::t_dp_status dp_st;

    // sequencer: decode, scan for the top entry, close the gap, hand off result
    apq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (dp_cmd),
        .i_st        (dp_st)
    );

    // datapath: entry store, count, scan registers and result register
    apq_dp #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_st           (dp_st),
        .i_command      (i_cmd.command),
        .i_element      (i_cmd.element),
        .i_priority_req (i_cmd.priority_req),
        .o_status       (o_res.status),
        .o_out_element  (o_res.out_element),
        .o_out_priority (o_res.out_priority),
        .o_fill_level   (o_res.fill_level)
    );

endmodule

// File: verif/tb_array_priority_queue_core.sv
module tb_array_priority_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = 8;
    localparam int PRIO_BITS   = 8;
    localparam int CLK_PERIOD  = 12;
    localparam int RESET_TICKS = 7;
    localparam int STALL_LIMIT = 2000;   // cycles with no beat on either side
    localparam int DRAIN_TICKS = 40;     // settle time after the last result
    localparam int RANDOM_BEATS = 1050;

    // priorities are kept in their low PRIO_BITS bits
    localparam logic [apq_pkg::PRIO_W-1:0] PRIO_MASK =
        apq_pkg::PRIO_W'((64'd1 << PRIO_BITS) - 64'd1);

    // unused command code, must produce a plain result
    localparam logic [apq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [apq_pkg::STATUS_W-1:0]      status;
        logic signed [apq_pkg::ELEM_W-1:0] element;
        logic [apq_pkg::PRIO_W-1:0]        prio_val;
        logic [apq_pkg::FILL_W-1:0]        fill;
    } t_queue_result;

    // mirror of the queue contents plus the list of results still owed
    class queue_scoreboard;
        logic signed [apq_pkg::ELEM_W-1:0] held_values[CAPACITY];
        logic [apq_pkg::PRIO_W-1:0]        held_prios[CAPACITY];
        int unsigned                       held_count;
        t_queue_result                     pending_results[$];
        int unsigned                       failures;

        // apply one accepted command to the mirror and queue its result
        function void note_command(logic [apq_pkg::CMD_W-1:0] cmd,
                                   logic signed [apq_pkg::ELEM_W-1:0] elem,
                                   logic [apq_pkg::PRIO_W-1:0] prio);
            t_queue_result res;
            int unsigned   top;
            int unsigned   i;
            res = '0;
            res.status = apq_pkg::ST_OK;
            case (cmd) inside
                apq_pkg::CMD_INSERT: begin
                    if (held_count >= CAPACITY) begin
                        res.status = apq_pkg::ST_FULL;
                    end else begin
                        held_values[held_count] = elem;
                        held_prios[held_count]  = prio & PRIO_MASK;
                        held_count++;
                    end
                end
                apq_pkg::CMD_PEEK, apq_pkg::CMD_REMOVE: begin
                    if (held_count == 0) begin
                        res.status = apq_pkg::ST_EMPTY;
                    end else begin
                        // strict compare keeps the oldest of equal priorities
                        top = 0;
                        for (i = 1; i < held_count; i++) begin
                            if (held_prios[i] > held_prios[top]) top = i;
                        end
                        res.prio_val = held_prios[top];
                        if (cmd == apq_pkg::CMD_REMOVE) begin
                            res.element = held_values[top];
                            for (i = top; i + 1 < held_count; i++) begin
                                held_values[i] = held_values[i + 1];
                                held_prios[i]  = held_prios[i + 1];
                            end
                            held_count--;
                        end
                    end
                end
                default: ;
            endcase
            res.fill = held_count[apq_pkg::FILL_W-1:0];
            pending_results.push_back(res);
        endfunction

        function void report_field(string name, longint expv, longint gotv);
            failures++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, gotv);
        endfunction

        // compare one result beat with the oldest owed result
        function void check_result(logic [apq_pkg::STATUS_W-1:0] status,
                                   logic signed [apq_pkg::ELEM_W-1:0] elem,
                                   logic [apq_pkg::PRIO_W-1:0] prio,
                                   logic [apq_pkg::FILL_W-1:0] fill);
            t_queue_result want;
            if (pending_results.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none actual status %0d elem %0d",
                         $time, status, elem);
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status)     report_field("status", want.status, status);
            if (elem !== want.element)      report_field("out_element", want.element, elem);
            if (prio !== want.prio_val)     report_field("out_priority", want.prio_val, prio);
            if (fill !== want.fill)         report_field("fill_level", want.fill, fill);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic idle_on;                 // random idling on both sides
    int unsigned stall_cycles = 0;
    queue_scoreboard board;

    apq_cmd_if cmd_if ();
    apq_res_if res_if ();

    array_priority_queue_core #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIO_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // free-running clock
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // one command beat: optional idle gap, then hold valid until taken
    task automatic send_command(input logic [apq_pkg::CMD_W-1:0] cmd,
                                input logic signed [apq_pkg::ELEM_W-1:0] elem,
                                input logic [apq_pkg::PRIO_W-1:0] prio);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(99) < 30) gap = $urandom_range(4, 1);
        repeat (gap) begin
            @(negedge i_clk);
            // junk payload while idle, must be ignored
            cmd_if.valid        <= 1'b0;
            cmd_if.command      <= apq_pkg::CMD_W'($urandom);
            cmd_if.element      <= $urandom;
            cmd_if.priority_req <= apq_pkg::PRIO_W'($urandom);
        end
        @(negedge i_clk);
        cmd_if.valid        <= 1'b1;
        cmd_if.command      <= cmd;
        cmd_if.element      <= elem;
        cmd_if.priority_req <= prio;
        do @(posedge i_clk); while (!cmd_if.ready);
        board.note_command(cmd, elem, prio);
    endtask

    // result side back-pressure, changes at the falling edge only
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready <= idle_on ? ($urandom_range(99) >= 30) : 1'b1;
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            board.check_result(res_if.status, res_if.out_element, res_if.out_priority,
                               res_if.fill_level);
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // main stimulus
    initial begin
        int unsigned n;
        int unsigned mode;
        int unsigned prio_kind;
        int unsigned roll;
        logic [apq_pkg::CMD_W-1:0]         cmd;
        logic signed [apq_pkg::ELEM_W-1:0] elem;
        logic [apq_pkg::PRIO_W-1:0]        prio;

        board = new();
        idle_on             = 1'b1;
        i_rst_n             = 1'b0;
        cmd_if.valid        = 1'b0;
        cmd_if.command      = apq_pkg::CMD_INSERT;
        cmd_if.element      = '0;
        cmd_if.priority_req = '0;
        mode                = 0;
        prio_kind           = 0;

        repeat (RESET_TICKS) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty queue, extremes, ties, full queue, drain in order
        send_command(apq_pkg::CMD_PEEK, 32'sd0, 8'd0);
        send_command(apq_pkg::CMD_REMOVE, 32'sd0, 8'd0);
        send_command(CMD_UNUSED, -32'sd1, 8'hff);
        send_command(apq_pkg::CMD_INSERT, 32'sh7fffffff, 8'd0);
        send_command(apq_pkg::CMD_INSERT, 32'sh80000000, 8'hff);
        send_command(apq_pkg::CMD_INSERT, 32'sd0, 8'hff);        // ties with the earlier 255
        send_command(apq_pkg::CMD_INSERT, -32'sd1, 8'd7);
        send_command(apq_pkg::CMD_INSERT, 32'sh5a5a5a5a, 8'd0);
        send_command(apq_pkg::CMD_INSERT, 32'sha5a5a5a5, 8'd7);
        send_command(apq_pkg::CMD_INSERT, 32'sd12345, 8'd128);
        send_command(apq_pkg::CMD_INSERT, -32'sd77, 8'd1);       // queue now full
        send_command(apq_pkg::CMD_INSERT, 32'sd99, 8'hff);       // refused, full
        send_command(CMD_UNUSED, 32'sd3, 8'd3);
        send_command(apq_pkg::CMD_PEEK, -32'sd1, 8'hff);
        for (n = 0; n < CAPACITY; n++) send_command(apq_pkg::CMD_REMOVE, 32'sd0, 8'd0);
        send_command(apq_pkg::CMD_REMOVE, 32'sd0, 8'd0);
        send_command(apq_pkg::CMD_PEEK, 32'sd0, 8'd0);

        // random: blocks biased toward filling, draining or a mix
        for (n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 24 == 0) begin
                mode      = $urandom_range(2);
                prio_kind = $urandom_range(2);
            end
            // a long stretch with no idling on either side
            idle_on = !(n >= 400 && n < 650);

            roll = $urandom_range(99);
            case (mode)
                0:       cmd = roll < 70 ? apq_pkg::CMD_INSERT : roll < 80 ? apq_pkg::CMD_PEEK :
                               roll < 95 ? apq_pkg::CMD_REMOVE : CMD_UNUSED;
                1:       cmd = roll < 20 ? apq_pkg::CMD_INSERT : roll < 35 ? apq_pkg::CMD_PEEK :
                               roll < 95 ? apq_pkg::CMD_REMOVE : CMD_UNUSED;
                default: cmd = roll < 45 ? apq_pkg::CMD_INSERT : roll < 60 ? apq_pkg::CMD_PEEK :
                               roll < 97 ? apq_pkg::CMD_REMOVE : CMD_UNUSED;
            endcase

            // narrow ranges give many ties, the full range walks every bit
            case (prio_kind)
                0:       prio = apq_pkg::PRIO_W'($urandom_range(3));
                1:       prio = apq_pkg::PRIO_W'($urandom);
                default: prio = $urandom_range(1) ? '1 : '0;
            endcase

            elem = ($urandom_range(99) < 30) ? apq_pkg::ELEM_W'($urandom_range(15))
                                             : apq_pkg::ELEM_W'($urandom);
            send_command(cmd, elem, prio);
        end

        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        idle_on = 1'b1;

        // wait for every owed result, then let the block settle
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TICKS) @(posedge i_clk);

        if (board.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
